// ===== rtl/core/ggac_pkg.sv =====
package ggac_pkg;

  // Field widths of the stream words and the register file.
  localparam int INDEX_BITS    = 12;
  localparam int SAMPLE_BITS   = 12;
  localparam int GAIN_BITS     = 16;
  localparam int REJECT_BITS   = 7;
  localparam int AMP_BITS      = 16;
  localparam int CFG_ADDR_BITS = 4;
  localparam int CFG_DATA_BITS = 16;

  // Product widths: magnitude times overall gain, then times gate gain.
  localparam int PROD1_BITS  = SAMPLE_BITS + GAIN_BITS;
  localparam int PROD2_BITS  = PROD1_BITS + GAIN_BITS;
  localparam int ROUND_SHIFT = 12;
  localparam int SCALED_BITS = PROD2_BITS + 1 - ROUND_SHIFT;

  // Full scale of 100 percent in units of 1/256 percent.
  localparam logic [AMP_BITS-2:0] FULL_SCALE = 15'd25600;
  localparam logic [GAIN_BITS-1:0] UNITY_GAIN = 16'd256;

  // Register indexes on the configuration port.
  localparam logic [CFG_ADDR_BITS-1:0] REG_OVERALL_GAIN = 4'd0;
  localparam logic [CFG_ADDR_BITS-1:0] REG_GATE_A_START = 4'd1;
  localparam logic [CFG_ADDR_BITS-1:0] REG_GATE_A_END   = 4'd2;
  localparam logic [CFG_ADDR_BITS-1:0] REG_GATE_A_GAIN  = 4'd3;
  localparam logic [CFG_ADDR_BITS-1:0] REG_GATE_B_START = 4'd4;
  localparam logic [CFG_ADDR_BITS-1:0] REG_GATE_B_END   = 4'd5;
  localparam logic [CFG_ADDR_BITS-1:0] REG_GATE_B_GAIN  = 4'd6;
  localparam logic [CFG_ADDR_BITS-1:0] REG_REJECT_LEVEL = 4'd7;

  // Which gate supplied the gain.
  typedef enum logic [1:0] {
    HIT_NONE = 2'd0,
    HIT_A    = 2'd1,
    HIT_B    = 2'd2
  } gate_hit_e;

  // Register file contents.
  typedef struct packed {
    logic [GAIN_BITS-1:0]   overall_gain;
    logic [INDEX_BITS-1:0]  gate_a_start;
    logic [INDEX_BITS-1:0]  gate_a_end;
    logic [GAIN_BITS-1:0]   gate_a_gain;
    logic [INDEX_BITS-1:0]  gate_b_start;
    logic [INDEX_BITS-1:0]  gate_b_end;
    logic [GAIN_BITS-1:0]   gate_b_gain;
    logic [REJECT_BITS-1:0] reject_level;
  } cfg_t;

  // Word after gate selection.
  typedef struct packed {
    logic                   neg;
    logic [SAMPLE_BITS-1:0] mag;
    logic [GAIN_BITS-1:0]   gain;
    logic [INDEX_BITS-1:0]  index;
    gate_hit_e              hit;
  } gate_word_t;

  // Word after both multiplications.
  typedef struct packed {
    logic                  neg;
    logic [PROD2_BITS-1:0] prod;
    logic [INDEX_BITS-1:0] index;
    gate_hit_e             hit;
  } prod_word_t;

  // Pipeline control shared by all stages.
  typedef struct packed {
    logic advance;
  } pipe_ctrl_t;

endpackage

// ===== rtl/core/gated_gain_amplitude_clamp.sv =====
// Gated gain and amplitude clamp for ultrasonic A-scan samples. Each input word
// carries a signed converter sample and its index in the scan line; each output
// word carries the amplitude in 1/256 percent (clamped to plus or minus 100
// percent, small magnitudes rejected to zero), the echoed index, and in tuser
// which gate's gain was applied (0 none, 1 gate A, 2 gate B). The block takes
// one word per clock while the output is not stalled; each word passes through
// the gate compare stage, the two registered multiplier stages and the rounding
// and clamp stage. A stall on the output holds the whole pipeline without loss.
// Configuration registers are written through the cfg port, which is always
// ready, and must only change while no word is in flight.
module gated_gain_amplitude_clamp (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Input stream.
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // Bits from low: sample_value[11:0], sample_index[23:12].
  input  logic [23:0]                          s_axis_tdata,
  // Output stream.
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // Bits from low: amplitude[15:0], position[27:16], zero fill[31:28].
  output logic [31:0]                          m_axis_tdata,
  // Bits from low: gate_hit[1:0].
  output logic [1:0]                           m_axis_tuser,
  // Configuration writes.
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [ggac_pkg::CFG_ADDR_BITS-1:0]   cfg_addr_i,
  input  logic [ggac_pkg::CFG_DATA_BITS-1:0]   cfg_data_i
);
  import ggac_pkg::*;

  cfg_t                  cfg_q;
  pipe_ctrl_t            ctrl;
  logic                  gate_valid;
  gate_word_t            gate_word;
  logic                  prod_valid;
  prod_word_t            prod_word;
  logic                  out_valid;
  logic [AMP_BITS-1:0]   amplitude;
  logic [INDEX_BITS-1:0] position;
  logic [1:0]            gate_hit;

  // Register file writes; unknown indexes are ignored.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.overall_gain <= 16'd200;
      cfg_q.gate_a_start <= '1;
      cfg_q.gate_a_end   <= '0;
      cfg_q.gate_a_gain  <= UNITY_GAIN;
      cfg_q.gate_b_start <= '1;
      cfg_q.gate_b_end   <= '0;
      cfg_q.gate_b_gain  <= UNITY_GAIN;
      cfg_q.reject_level <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_addr_i)
        REG_OVERALL_GAIN: cfg_q.overall_gain <= cfg_data_i[GAIN_BITS-1:0];
        REG_GATE_A_START: cfg_q.gate_a_start <= cfg_data_i[INDEX_BITS-1:0];
        REG_GATE_A_END:   cfg_q.gate_a_end   <= cfg_data_i[INDEX_BITS-1:0];
        REG_GATE_A_GAIN:  cfg_q.gate_a_gain  <= cfg_data_i[GAIN_BITS-1:0];
        REG_GATE_B_START: cfg_q.gate_b_start <= cfg_data_i[INDEX_BITS-1:0];
        REG_GATE_B_END:   cfg_q.gate_b_end   <= cfg_data_i[INDEX_BITS-1:0];
        REG_GATE_B_GAIN:  cfg_q.gate_b_gain  <= cfg_data_i[GAIN_BITS-1:0];
        REG_REJECT_LEVEL: cfg_q.reject_level <= cfg_data_i[REJECT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // The pipeline moves whenever the output word is empty or being taken.
  assign ctrl.advance  = !out_valid || m_axis_tready;
  assign s_axis_tready = ctrl.advance;

  ggac_gate_select u_gate_select (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (ctrl),
    .valid_i        (s_axis_tvalid),
    .sample_value_i (s_axis_tdata[SAMPLE_BITS-1:0]),
    .sample_index_i (s_axis_tdata[SAMPLE_BITS+INDEX_BITS-1:SAMPLE_BITS]),
    .cfg_i          (cfg_q),
    .valid_o        (gate_valid),
    .word_o         (gate_word)
  );

  ggac_gain_mult u_gain_mult (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (ctrl),
    .valid_i        (gate_valid),
    .word_i         (gate_word),
    .overall_gain_i (cfg_q.overall_gain),
    .valid_o        (prod_valid),
    .word_o         (prod_word)
  );

  ggac_clamp u_clamp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (ctrl),
    .valid_i        (prod_valid),
    .word_i         (prod_word),
    .reject_level_i (cfg_q.reject_level),
    .valid_o        (out_valid),
    .amplitude_o    (amplitude),
    .position_o     (position),
    .gate_hit_o     (gate_hit)
  );

  // Output word packing.
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {(32 - AMP_BITS - INDEX_BITS)'(0), position, amplitude};
  assign m_axis_tuser  = gate_hit;

endmodule

// ===== rtl/core/ggac_gate_select.sv =====
module ggac_gate_select (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  ggac_pkg::pipe_ctrl_t               ctrl_i,
  input  logic                               valid_i,
  input  logic signed [ggac_pkg::SAMPLE_BITS-1:0] sample_value_i,
  input  logic [ggac_pkg::INDEX_BITS-1:0]    sample_index_i,
  input  ggac_pkg::cfg_t                     cfg_i,
  output logic                               valid_o,
  output ggac_pkg::gate_word_t               word_o
);
  import ggac_pkg::*;

  logic       in_a;
  logic       in_b;
  gate_word_t word_d;
  gate_word_t word_q;
  logic       valid_q;

  // Inclusive window tests; a gate with start above end never matches.
  assign in_a = (cfg_i.gate_a_start <= cfg_i.gate_a_end) &&
                (sample_index_i >= cfg_i.gate_a_start) &&
                (sample_index_i <= cfg_i.gate_a_end);
  assign in_b = (cfg_i.gate_b_start <= cfg_i.gate_b_end) &&
                (sample_index_i >= cfg_i.gate_b_start) &&
                (sample_index_i <= cfg_i.gate_b_end);

  // Gate A wins on overlap. The magnitude of the most negative sample fits unsigned.
  always_comb begin
    word_d.neg   = sample_value_i[SAMPLE_BITS-1];
    word_d.mag   = sample_value_i[SAMPLE_BITS-1] ? (~sample_value_i + 1'b1) : sample_value_i;
    word_d.index = sample_index_i;
    if (in_a) begin
      word_d.gain = cfg_i.gate_a_gain;
      word_d.hit  = HIT_A;
    end else if (in_b) begin
      word_d.gain = cfg_i.gate_b_gain;
      word_d.hit  = HIT_B;
    end else begin
      word_d.gain = UNITY_GAIN;
      word_d.hit  = HIT_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctrl_i.advance) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.advance) begin
      word_q <= word_d;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

// ===== rtl/core/ggac_gain_mult.sv =====
module ggac_gain_mult (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ggac_pkg::pipe_ctrl_t          ctrl_i,
  input  logic                          valid_i,
  input  ggac_pkg::gate_word_t          word_i,
  input  logic [ggac_pkg::GAIN_BITS-1:0] overall_gain_i,
  output logic                          valid_o,
  output ggac_pkg::prod_word_t          word_o
);
  import ggac_pkg::*;

  // First stage: magnitude times overall gain.
  logic                  s1_valid_q;
  logic                  s1_neg_q;
  logic [PROD1_BITS-1:0] s1_prod_q;
  logic [GAIN_BITS-1:0]  s1_gain_q;
  logic [INDEX_BITS-1:0] s1_index_q;
  gate_hit_e             s1_hit_q;
  logic [PROD1_BITS-1:0] s1_prod_d;

  // Second stage: times the selected gate gain.
  logic                  s2_valid_q;
  prod_word_t            s2_word_q;
  prod_word_t            s2_word_d;

  assign s1_prod_d = PROD1_BITS'(word_i.mag) * PROD1_BITS'(overall_gain_i);

  always_comb begin
    s2_word_d.neg   = s1_neg_q;
    s2_word_d.prod  = PROD2_BITS'(s1_prod_q) * PROD2_BITS'(s1_gain_q);
    s2_word_d.index = s1_index_q;
    s2_word_d.hit   = s1_hit_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else if (ctrl_i.advance) begin
      s1_valid_q <= valid_i;
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.advance) begin
      s1_neg_q   <= word_i.neg;
      s1_prod_q  <= s1_prod_d;
      s1_gain_q  <= word_i.gain;
      s1_index_q <= word_i.index;
      s1_hit_q   <= word_i.hit;
      s2_word_q  <= s2_word_d;
    end
  end

  assign valid_o = s2_valid_q;
  assign word_o  = s2_word_q;

endmodule

// ===== rtl/core/ggac_clamp.sv =====
module ggac_clamp (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  ggac_pkg::pipe_ctrl_t             ctrl_i,
  input  logic                             valid_i,
  input  ggac_pkg::prod_word_t             word_i,
  input  logic [ggac_pkg::REJECT_BITS-1:0] reject_level_i,
  output logic                             valid_o,
  output logic signed [ggac_pkg::AMP_BITS-1:0] amplitude_o,
  output logic [ggac_pkg::INDEX_BITS-1:0]  position_o,
  output logic [1:0]                       gate_hit_o
);
  import ggac_pkg::*;

  logic [PROD2_BITS:0]    rounded;
  logic [SCALED_BITS-1:0] scaled;
  logic [AMP_BITS-2:0]    clamped;
  logic [AMP_BITS-2:0]    reject_floor;
  logic [AMP_BITS-2:0]    kept;
  logic [AMP_BITS-1:0]    amp_d;
  logic                   valid_q;
  logic [AMP_BITS-1:0]    amp_q;
  logic [INDEX_BITS-1:0]  position_q;
  gate_hit_e              hit_q;

  // Round to nearest on the magnitude, so ties go away from zero.
  assign rounded = {1'b0, word_i.prod} + ((PROD2_BITS + 1)'(1) << (ROUND_SHIFT - 1));
  assign scaled  = rounded[PROD2_BITS:ROUND_SHIFT];

  // Saturate at full scale, then reject small magnitudes.
  assign clamped      = (scaled > SCALED_BITS'(FULL_SCALE)) ? FULL_SCALE
                                                            : scaled[AMP_BITS-2:0];
  assign reject_floor = {reject_level_i, 8'd0};
  assign kept         = (clamped < reject_floor) ? '0 : clamped;

  // Restore the sample's sign.
  assign amp_d = word_i.neg ? (~{1'b0, kept} + 1'b1) : {1'b0, kept};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctrl_i.advance) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.advance) begin
      amp_q      <= amp_d;
      position_q <= word_i.index;
      hit_q      <= word_i.hit;
    end
  end

  assign valid_o     = valid_q;
  assign amplitude_o = amp_q;
  assign position_o  = position_q;
  assign gate_hit_o  = hit_q;

endmodule

// ===== tb/ggac_amp_checker.sv =====
module ggac_amp_checker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Input stream as seen at the block.
  input  logic                               in_valid_i,
  input  logic                               in_ready_i,
  // Bits from low: sample_value[11:0], sample_index[23:12].
  input  logic [23:0]                        in_data_i,
  // Output stream as seen at the block.
  input  logic                               out_valid_i,
  input  logic                               out_ready_i,
  // Bits from low: amplitude[15:0], position[27:16], zero fill[31:28].
  input  logic [31:0]                        out_data_i,
  // Bits from low: gate_hit[1:0].
  input  logic [1:0]                         out_user_i,
  // Configuration writes.
  input  logic                               cfg_valid_i,
  input  logic                               cfg_ready_i,
  input  logic [ggac_pkg::CFG_ADDR_BITS-1:0] cfg_addr_i,
  input  logic [ggac_pkg::CFG_DATA_BITS-1:0] cfg_data_i,
  output int                                 fail_count_o,
  output int                                 pending_o
);
  import ggac_pkg::*;

  // One conditioned amplitude word as the block should deliver it.
  typedef struct packed {
    logic [AMP_BITS-1:0]   amplitude;
    logic [INDEX_BITS-1:0] position;
    gate_hit_e             hit;
  } amp_word_t;

  cfg_t      regs;
  amp_word_t expected_amps[$];

  // A gate whose start lies above its end never matches.
  function automatic bit in_gate(input logic [INDEX_BITS-1:0] idx,
                                 input logic [INDEX_BITS-1:0] lo,
                                 input logic [INDEX_BITS-1:0] hi);
    return (lo <= hi) && (idx >= lo) && (idx <= hi);
  endfunction

  // Gain, round, clamp and reject on the magnitude, then restore the sign.
  function automatic amp_word_t condition_sample(input logic [SAMPLE_BITS-1:0] raw,
                                                 input logic [INDEX_BITS-1:0] idx,
                                                 input cfg_t r);
    logic              neg;
    longint unsigned   mag;
    longint unsigned   gain;
    longint unsigned   m;
    amp_word_t         w;
    neg = raw[SAMPLE_BITS-1];
    // The most negative sample keeps its full magnitude.
    if (neg) begin
      mag = (64'd1 << SAMPLE_BITS) - 64'(raw);
    end else begin
      mag = 64'(raw);
    end
    gain  = 64'(UNITY_GAIN);
    w.hit = HIT_NONE;
    // Gate A wins where the windows overlap.
    if (in_gate(idx, r.gate_a_start, r.gate_a_end)) begin
      gain  = 64'(r.gate_a_gain);
      w.hit = HIT_A;
    end else if (in_gate(idx, r.gate_b_start, r.gate_b_end)) begin
      gain  = 64'(r.gate_b_gain);
      w.hit = HIT_B;
    end
    m = (mag * 64'(r.overall_gain) * gain + 64'd2048) >> ROUND_SHIFT;
    if (m > 64'(FULL_SCALE)) begin
      m = 64'(FULL_SCALE);
    end
    if (m < 64'(r.reject_level) * 64'd256) begin
      m = 64'd0;
    end
    if (neg) begin
      w.amplitude = AMP_BITS'(64'd0 - m);
    end else begin
      w.amplitude = AMP_BITS'(m);
    end
    w.position = idx;
    return w;
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t mismatch: %s", $time, what);
    fail_count_o++;
  endtask

  // Track register writes, predict each accepted sample, compare each result word.
  always @(posedge clk_i or negedge rst_ni) begin
    amp_word_t got;
    amp_word_t want;
    if (!rst_ni) begin
      regs.overall_gain = 16'd200;
      regs.gate_a_start = 12'd4095;
      regs.gate_a_end   = 12'd0;
      regs.gate_a_gain  = 16'd256;
      regs.gate_b_start = 12'd4095;
      regs.gate_b_end   = 12'd0;
      regs.gate_b_gain  = 16'd256;
      regs.reject_level = 7'd0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_addr_i)
          REG_OVERALL_GAIN: regs.overall_gain = cfg_data_i[GAIN_BITS-1:0];
          REG_GATE_A_START: regs.gate_a_start = cfg_data_i[INDEX_BITS-1:0];
          REG_GATE_A_END:   regs.gate_a_end   = cfg_data_i[INDEX_BITS-1:0];
          REG_GATE_A_GAIN:  regs.gate_a_gain  = cfg_data_i[GAIN_BITS-1:0];
          REG_GATE_B_START: regs.gate_b_start = cfg_data_i[INDEX_BITS-1:0];
          REG_GATE_B_END:   regs.gate_b_end   = cfg_data_i[INDEX_BITS-1:0];
          REG_GATE_B_GAIN:  regs.gate_b_gain  = cfg_data_i[GAIN_BITS-1:0];
          REG_REJECT_LEVEL: regs.reject_level = cfg_data_i[REJECT_BITS-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        expected_amps.push_back(condition_sample(in_data_i[SAMPLE_BITS-1:0],
                                                 in_data_i[SAMPLE_BITS +: INDEX_BITS],
                                                 regs));
      end
      if (out_valid_i && out_ready_i) begin
        got.amplitude = out_data_i[AMP_BITS-1:0];
        got.position  = out_data_i[AMP_BITS +: INDEX_BITS];
        got.hit       = gate_hit_e'(out_user_i);
        if (expected_amps.size() == 0) begin
          report_mismatch($sformatf("amplitude word %h with nothing expected", out_data_i));
        end else begin
          want = expected_amps.pop_front();
          if (got.amplitude !== want.amplitude) begin
            report_mismatch($sformatf("amplitude %h, expected %h at index %0d",
                                      got.amplitude, want.amplitude, want.position));
          end
          if (got.position !== want.position) begin
            report_mismatch($sformatf("position %0d, expected %0d",
                                      got.position, want.position));
          end
          if (got.hit !== want.hit) begin
            report_mismatch($sformatf("gate hit %0d, expected %0d at index %0d",
                                      out_user_i, want.hit, want.position));
          end
        end
      end
    end
    pending_o = expected_amps.size();
  end

endmodule

// ===== tb/tb_gated_gain_amplitude_clamp.sv =====
module tb_gated_gain_amplitude_clamp;
  import ggac_pkg::*;

  localparam int HOLD_CYCLES  = 400;
  localparam int IDLE_LIMIT   = 3000;
  localparam int DRAIN_CYCLES = 10;
  localparam int PHASES       = 14;
  localparam int PHASE_ITEMS  = 110;
  localparam int LAST_REG     = (1 << CFG_ADDR_BITS) - 1;
  localparam logic [CFG_ADDR_BITS-1:0] FIRST_UNUSED_REG = 4'd8;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     s_axis_tvalid;
  logic                     s_axis_tready;
  logic [23:0]              s_axis_tdata;
  logic                     m_axis_tvalid;
  logic                     m_axis_tready;
  logic [31:0]              m_axis_tdata;
  logic [1:0]               m_axis_tuser;
  logic                     cfg_valid_i;
  logic                     cfg_ready_o;
  logic [CFG_ADDR_BITS-1:0] cfg_addr_i;
  logic [CFG_DATA_BITS-1:0] cfg_data_i;

  int mismatch_count;
  int amps_pending;
  bit tx_gaps_on;
  bit rx_gaps_on;
  int holds_wanted;

  gated_gain_amplitude_clamp dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i)
  );

  ggac_amp_checker amp_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_i   (s_axis_tready),
    .in_data_i    (s_axis_tdata),
    .out_valid_i  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_i   (m_axis_tdata),
    .out_user_i   (m_axis_tuser),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_data_i   (cfg_data_i),
    .fail_count_o (mismatch_count),
    .pending_o    (amps_pending)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] rand_sample();
    case ($urandom_range(0, 9))
      0:       return 12'h800;
      1:       return 12'h7FF;
      2:       return 12'($urandom_range(0, 6)) - 12'd3;
      default: return 12'($urandom);
    endcase
  endfunction

  // Half of the indexes fall on or next to a gate edge.
  function automatic logic [INDEX_BITS-1:0] rand_index(input cfg_t s);
    logic [INDEX_BITS-1:0] base;
    if ($urandom_range(0, 9) >= 5) return 12'($urandom);
    case ($urandom_range(0, 3))
      0:       base = s.gate_a_start;
      1:       base = s.gate_a_end;
      2:       base = s.gate_b_start;
      default: base = s.gate_b_end;
    endcase
    return base + 12'($urandom_range(0, 2)) - 12'd1;
  endfunction

  function automatic logic [GAIN_BITS-1:0] rand_gain();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return 16'($urandom_range(0, 1024));
      6:                return 16'd0;
      7:                return 16'hFFFF;
      default:          return 16'($urandom);
    endcase
  endfunction

  // Normal, disabled or full-range gate window.
  function automatic void rand_window(output logic [INDEX_BITS-1:0] lo,
                                      output logic [INDEX_BITS-1:0] hi);
    int r;
    int start;
    r     = $urandom_range(0, 9);
    start = $urandom_range(1, 4095);
    if (r < 7) begin
      lo = 12'(start);
      hi = 12'((start + $urandom_range(0, 600) > 4095) ? 4095
                                                        : start + $urandom_range(0, 600));
    end else if (r < 9) begin
      lo = 12'(start);
      hi = 12'($urandom_range(0, start - 1));
    end else begin
      lo = 12'd0;
      hi = 12'd4095;
    end
  endfunction

  function automatic cfg_t rand_settings();
    cfg_t s;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: s.overall_gain = 16'($urandom_range(100, 300));
      6:                s.overall_gain = 16'hFFFF;
      7:                s.overall_gain = 16'd0;
      default:          s.overall_gain = 16'($urandom);
    endcase
    rand_window(s.gate_a_start, s.gate_a_end);
    rand_window(s.gate_b_start, s.gate_b_end);
    s.gate_a_gain = rand_gain();
    s.gate_b_gain = rand_gain();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: s.reject_level = 7'($urandom_range(0, 20));
      5:             s.reject_level = 7'd0;
      6:             s.reject_level = 7'd100;
      7:             s.reject_level = 7'd127;
      default:       s.reject_level = 7'($urandom_range(0, 100));
    endcase
    return s;
  endfunction

  function automatic cfg_t make_setting(input logic [GAIN_BITS-1:0] og,
                                        input logic [INDEX_BITS-1:0] as,
                                        input logic [INDEX_BITS-1:0] ae,
                                        input logic [GAIN_BITS-1:0] ag,
                                        input logic [INDEX_BITS-1:0] bs,
                                        input logic [INDEX_BITS-1:0] be,
                                        input logic [GAIN_BITS-1:0] bg,
                                        input logic [REJECT_BITS-1:0] rej);
    cfg_t s;
    s.overall_gain = og;
    s.gate_a_start = as;
    s.gate_a_end   = ae;
    s.gate_a_gain  = ag;
    s.gate_b_start = bs;
    s.gate_b_end   = be;
    s.gate_b_gain  = bg;
    s.reject_level = rej;
    return s;
  endfunction

  // Offer one sample word after an optional gap; valid stays high on return.
  task automatic push_sample(input logic [SAMPLE_BITS-1:0] value,
                             input logic [INDEX_BITS-1:0] index);
    int gap;
    gap = tx_gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata  <= {index, value};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  // Stop offering and wait until every amplitude word has come back.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (amps_pending != 0) @(negedge clk_i);
  endtask

  // One register write; valid stays high on return.
  task automatic write_reg(input logic [CFG_ADDR_BITS-1:0] addr,
                           input logic [CFG_DATA_BITS-1:0] data);
    cfg_addr_i  <= addr;
    cfg_data_i  <= data;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
  endtask

  // Write all registers, with junk above the narrow fields, then one unused index.
  task automatic program_regs(input cfg_t s);
    logic [CFG_DATA_BITS-1:0] junk;
    junk = 16'($urandom);
    write_reg(REG_OVERALL_GAIN, s.overall_gain);
    write_reg(REG_GATE_A_START, {junk[CFG_DATA_BITS-1:INDEX_BITS], s.gate_a_start});
    junk = 16'($urandom);
    write_reg(REG_GATE_A_END, {junk[CFG_DATA_BITS-1:INDEX_BITS], s.gate_a_end});
    write_reg(REG_GATE_A_GAIN, s.gate_a_gain);
    junk = 16'($urandom);
    write_reg(REG_GATE_B_START, {junk[CFG_DATA_BITS-1:INDEX_BITS], s.gate_b_start});
    junk = 16'($urandom);
    write_reg(REG_GATE_B_END, {junk[CFG_DATA_BITS-1:INDEX_BITS], s.gate_b_end});
    write_reg(REG_GATE_B_GAIN, s.gate_b_gain);
    junk = 16'($urandom);
    write_reg(REG_REJECT_LEVEL, {junk[CFG_DATA_BITS-1:REJECT_BITS], s.reject_level});
    write_reg(CFG_ADDR_BITS'($urandom_range(FIRST_UNUSED_REG, LAST_REG)), 16'($urandom));
    cfg_valid_i <= 1'b0;
  endtask

  // Receiver: random stalls, plus a long hold-off whenever one is requested.
  initial begin
    int hold_left;
    int stall_left;
    int holds_served;
    hold_left     = 0;
    stall_left    = 0;
    holds_served  = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (holds_served < holds_wanted) begin
        holds_served++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (rx_gaps_on) stall_left = pick_gap();
      end
    end
  end

  // Watchdog on cycles in which no channel moves a word.
  initial begin
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle = 0;
      end else begin
        idle++;
      end
    end
    $display("gated_gain_amplitude_clamp regression: fail");
    $finish;
  end

  // Stimulus and verdict.
  initial begin
    cfg_t setting;
    int   p;
    int   i;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_valid_i   = 1'b0;
    cfg_addr_i    = '0;
    cfg_data_i    = '0;
    rst_ni        = 1'b0;
    tx_gaps_on    = 1'b1;
    rx_gaps_on    = 1'b1;
    holds_wanted  = 0;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset settings: both gates disabled, unity gate gain, overall gain 200.
    push_sample(12'h7FF, 12'd10);
    push_sample(12'h800, 12'd4095);

    // Overlapping gates, window edges and rejection of small magnitudes.
    drain_results();
    program_regs(make_setting(16'd200, 12'd100, 12'd200, 16'd512,
                              12'd150, 12'd300, 16'd128, 7'd10));
    push_sample(12'h7FF, 12'd100);
    push_sample(12'h800, 12'd200);
    push_sample(12'(1000), 12'd150);
    push_sample(12'(-1000), 12'd201);
    push_sample(12'(500), 12'd300);
    push_sample(12'(500), 12'd301);
    push_sample(12'hFFF, 12'd99);
    push_sample(12'd0, 12'd0);
    push_sample(12'd1, 12'd4095);
    push_sample(12'(20), 12'd250);

    // Zero gate gain against a full-scale gate gain and overall gain.
    drain_results();
    program_regs(make_setting(16'hFFFF, 12'd0, 12'd4095, 16'd0,
                              12'd0, 12'd4095, 16'hFFFF, 7'd0));
    push_sample(12'h7FF, 12'd7);
    push_sample(12'h800, 12'd3000);

    // Gate A disabled, gate B everywhere, rejection at full scale.
    drain_results();
    program_regs(make_setting(16'hFFFF, 12'd4095, 12'd4094, 16'hFFFF,
                              12'd0, 12'd4095, 16'hFFFF, 7'd100));
    push_sample(12'h7FF, 12'd0);
    push_sample(12'h800, 12'd4095);
    push_sample(12'd1, 12'd5);

    // Zero overall gain, single-index gate, rejection level above the range.
    drain_results();
    program_regs(make_setting(16'd0, 12'd5, 12'd5, 16'hFFFF,
                              12'd9, 12'd8, 16'd256, 7'd127));
    push_sample(12'h7FF, 12'd5);
    push_sample(12'h800, 12'd6);

    // Gates on the first and the last index.
    drain_results();
    program_regs(make_setting(16'd200, 12'd0, 12'd0, 16'd256,
                              12'd4095, 12'd4095, 16'd256, 7'd0));
    push_sample(12'h800, 12'd0);
    push_sample(12'h7FF, 12'd4095);
    push_sample(12'd0, 12'd1);

    // Random phases, each under fresh settings.
    for (p = 0; p < PHASES; p++) begin
      drain_results();
      setting = rand_settings();
      program_regs(setting);
      tx_gaps_on = (p % 4 != 2) && (p != 3);
      rx_gaps_on = (p % 4 != 2);
      // Fill the pipeline against a long receiver hold-off.
      if (p == 3) holds_wanted++;
      for (i = 0; i < PHASE_ITEMS; i++) begin
        if ((p == 5 && i == PHASE_ITEMS / 2) || $urandom_range(0, 299) == 0) begin
          drain_results();
        end
        push_sample(rand_sample(), rand_index(setting));
      end
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (mismatch_count == 0 && amps_pending == 0) begin
      $display("gated_gain_amplitude_clamp regression: pass");
    end else begin
      $display("gated_gain_amplitude_clamp regression: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/ggac_pkg.sv
rtl/core/ggac_gate_select.sv
rtl/core/ggac_gain_mult.sv
rtl/core/ggac_clamp.sv
rtl/core/gated_gain_amplitude_clamp.sv
tb/ggac_amp_checker.sv
tb/tb_gated_gain_amplitude_clamp.sv
